@@ rtl/tms_pkg.sv @@
// Shared types and constants for the triangle midpoint subdivision block.
// Holds command codes, controller states and the controller/datapath structs.
// No dependencies.
package tms_pkg;

    localparam int CMD_W      = 2;
    localparam int CORNER_W   = 8;
    localparam int BASE_W     = 9;
    localparam int BASE_RESET = 12;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_BEGIN = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_LOAD,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_MID,
        ST_REV,
        ST_TRI
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       capture;
        logic       load_store;
        logic       begin_mesh;
        logic       clr_step;
        logic       edge_rd;
        logic       edge_miss;
        logic       mid_emit;
        logic       rev_wr;
        logic       hit_keep;
        logic       tri_emit;
        logic [1:0] edge_sel;
        logic [1:0] tri_sel;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic load_full;
        logic map_hit;
        logic out_free;
        logic clr_last;
    } dp_sts_t;

endpackage

@@ rtl/tms_ctrl.sv @@
// Controller state machine for the triangle midpoint subdivision block.
// Sequences map clearing, vertex loads, edge lookups and triangle output.
// Depends on tms_pkg.
module tms_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tms_pkg::dp_sts_t  sts,
    output tms_pkg::dp_cmd_t  cmd
);

    tms_pkg::state_t state_reg, state_next;
    logic [1:0]      edge_reg, edge_next;
    logic [1:0]      tri_reg, tri_next;

    // State register; reset starts the map clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tms_pkg::ST_CLEAR;
            edge_reg  <= 2'd0;
            tri_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            tri_reg   <= tri_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        edge_next    = edge_reg;
        tri_next     = tri_reg;
        cmd          = '0;
        cmd.edge_sel = edge_reg;
        cmd.tri_sel  = tri_reg;
        s_ready      = 1'b0;
        case (state_reg)
            tms_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = tms_pkg::ST_DISPATCH;
                end
            end
            tms_pkg::ST_DISPATCH: begin
                case (sts.cmd)
                    tms_pkg::CMD_LOAD: begin
                        state_next = sts.load_full ? tms_pkg::ST_IDLE : tms_pkg::ST_LOAD;
                    end
                    tms_pkg::CMD_TRI: begin
                        edge_next  = 2'd0;
                        state_next = tms_pkg::ST_EDGE_RD;
                    end
                    tms_pkg::CMD_BEGIN: begin
                        cmd.begin_mesh = 1'b1;
                        state_next     = tms_pkg::ST_CLEAR;
                    end
                    default: begin
                        state_next = tms_pkg::ST_IDLE;
                    end
                endcase
            end
            tms_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = tms_pkg::ST_IDLE;
                end
            end
            tms_pkg::ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load_store = 1'b1;
                    state_next     = tms_pkg::ST_IDLE;
                end
            end
            tms_pkg::ST_EDGE_RD: begin
                cmd.edge_rd = 1'b1;
                state_next  = tms_pkg::ST_EDGE_CHK;
            end
            tms_pkg::ST_EDGE_CHK: begin
                if (sts.map_hit) begin
                    cmd.hit_keep = 1'b1;
                    if (edge_reg == 2'd2) begin
                        tri_next   = 2'd0;
                        state_next = tms_pkg::ST_TRI;
                    end else begin
                        edge_next  = edge_reg + 2'd1;
                        state_next = tms_pkg::ST_EDGE_RD;
                    end
                end else begin
                    cmd.edge_miss = 1'b1;
                    state_next    = tms_pkg::ST_MID;
                end
            end
            tms_pkg::ST_MID: begin
                if (sts.out_free) begin
                    cmd.mid_emit = 1'b1;
                    state_next   = tms_pkg::ST_REV;
                end
            end
            tms_pkg::ST_REV: begin
                cmd.rev_wr = 1'b1;
                if (edge_reg == 2'd2) begin
                    tri_next   = 2'd0;
                    state_next = tms_pkg::ST_TRI;
                end else begin
                    edge_next  = edge_reg + 2'd1;
                    state_next = tms_pkg::ST_EDGE_RD;
                end
            end
            tms_pkg::ST_TRI: begin
                if (sts.out_free) begin
                    cmd.tri_emit = 1'b1;
                    if (tri_reg == 2'd3) begin
                        state_next = tms_pkg::ST_IDLE;
                    end else begin
                        tri_next = tri_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = tms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tms_datapath.sv @@
// Datapath for the triangle midpoint subdivision block: vertex store, edge map,
// counters, midpoint adders and the result register.
// Depends on tms_pkg.
module tms_datapath #(
    parameter int MAX_IN_VERTICES  = 256,
    parameter int MAX_OUT_VERTICES = 1024,
    parameter int COORD_BITS       = 18
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tms_pkg::dp_cmd_t                     cmd,
    output tms_pkg::dp_sts_t                     sts,
    input  logic [tms_pkg::BASE_W-1:0]           base_count,
    input  logic [tms_pkg::CMD_W-1:0]            s_cmd,
    input  logic signed [COORD_BITS-1:0]         s_pos_x,
    input  logic signed [COORD_BITS-1:0]         s_pos_y,
    input  logic signed [COORD_BITS-1:0]         s_pos_z,
    input  logic [tms_pkg::CORNER_W-1:0]         s_corner_a,
    input  logic [tms_pkg::CORNER_W-1:0]         s_corner_b,
    input  logic [tms_pkg::CORNER_W-1:0]         s_corner_c,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic [$clog2(MAX_OUT_VERTICES)-1:0]  m_vert_idx,
    output logic signed [COORD_BITS-1:0]         m_out_x,
    output logic signed [COORD_BITS-1:0]         m_out_y,
    output logic signed [COORD_BITS-1:0]         m_out_z,
    output logic [$clog2(MAX_OUT_VERTICES)-1:0]  m_tri_a,
    output logic [$clog2(MAX_OUT_VERTICES)-1:0]  m_tri_b,
    output logic [$clog2(MAX_OUT_VERTICES)-1:0]  m_tri_c,
    output logic                                 m_last,
    output logic                                 m_overflow
);

    localparam int IW   = $clog2(MAX_IN_VERTICES);
    localparam int LCW  = $clog2(MAX_IN_VERTICES + 1);
    localparam int OIW  = $clog2(MAX_OUT_VERTICES);
    localparam int NNW  = (OIW + 1 > tms_pkg::BASE_W) ? OIW + 1 : tms_pkg::BASE_W + 1;
    localparam int MD   = MAX_IN_VERTICES * MAX_IN_VERTICES;
    localparam int AW   = $clog2(MD);
    localparam int CB   = COORD_BITS;
    localparam int VW   = 3 * COORD_BITS;
    localparam int EW   = OIW + 1;

    // Corner index modulo the store depth, one restoring subtract per bit
    function automatic logic [IW-1:0] corner_mod(input logic [tms_pkg::CORNER_W-1:0] v);
        logic [tms_pkg::CORNER_W-1:0] r;
        r = v;
        for (int k = tms_pkg::CORNER_W - 1; k >= 0; k--) begin
            if (32'(r) >= (32'(MAX_IN_VERTICES) << k)) begin
                r = r - tms_pkg::CORNER_W'(32'(MAX_IN_VERTICES) << k);
            end
        end
        return IW'(r);
    endfunction

    function automatic logic [CB-1:0] half_sum(input logic [CB-1:0] p, input logic [CB-1:0] q);
        logic [CB:0] s;
        s = {p[CB-1], p} + {q[CB-1], q};
        return s[CB:1];
    endfunction

    logic [VW-1:0]  vstore [MAX_IN_VERTICES];
    logic [EW-1:0]  emap   [MD];

    tms_pkg::cmd_t  cmd_reg;
    logic [VW-1:0]  pos_reg;
    logic [IW-1:0]  a_reg, b_reg, c_reg;
    logic [OIW-1:0] mid_reg [3];
    logic           any_ovf_reg;
    logic [LCW-1:0] load_count_reg;
    logic [NNW-1:0] nni_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic [EW-1:0]  map_rd_reg;
    logic [VW-1:0]  vs_rd_reg;
    logic [VW-1:0]  pu_reg;

    logic [IW-1:0]  u, v;
    logic [AW-1:0]  fwd_addr, rev_addr;
    logic           map_we;
    logic [AW-1:0]  map_wa;
    logic [EW-1:0]  map_wd;
    logic [IW-1:0]  vs_ra;
    logic           nni_full;
    logic [OIW-1:0] new_idx;
    logic [VW-1:0]  mid_pos;

    // Edge endpoints and map addresses
    always_comb begin
        case (cmd.edge_sel)
            2'd0: begin
                u = a_reg;
                v = b_reg;
            end
            2'd1: begin
                u = b_reg;
                v = c_reg;
            end
            default: begin
                u = c_reg;
                v = a_reg;
            end
        endcase
        fwd_addr = AW'(AW'(u) * AW'(MAX_IN_VERTICES)) + AW'(v);
        rev_addr = AW'(AW'(v) * AW'(MAX_IN_VERTICES)) + AW'(u);
        vs_ra    = cmd.edge_miss ? v : u;
    end

    // Allocate the next midpoint index; saturate when exhausted
    assign nni_full = (nni_reg >= NNW'(MAX_OUT_VERTICES));
    assign new_idx  = nni_full ? OIW'(MAX_OUT_VERTICES - 1) : OIW'(nni_reg);

    assign mid_pos = {half_sum(pu_reg[VW-1 -: CB], vs_rd_reg[VW-1 -: CB]),
                      half_sum(pu_reg[2*CB-1 -: CB], vs_rd_reg[2*CB-1 -: CB]),
                      half_sum(pu_reg[CB-1:0], vs_rd_reg[CB-1:0])};

    // Edge map write port: clear sweep, forward entry, reverse entry
    always_comb begin
        map_we = 1'b0;
        map_wa = fwd_addr;
        map_wd = {1'b1, new_idx};
        if (cmd.clr_step) begin
            map_we = 1'b1;
            map_wa = clr_addr_reg;
            map_wd = '0;
        end else if (cmd.mid_emit) begin
            map_we = 1'b1;
        end else if (cmd.rev_wr) begin
            map_we = 1'b1;
            map_wa = rev_addr;
            map_wd = {1'b1, mid_reg[cmd.edge_sel]};
        end
    end

    // Edge map memory
    always_ff @(posedge aclk) begin
        if (map_we) begin
            emap[map_wa] <= map_wd;
        end
        if (cmd.edge_rd) begin
            map_rd_reg <= emap[fwd_addr];
        end
    end

    // Vertex store memory
    always_ff @(posedge aclk) begin
        if (cmd.load_store) begin
            vstore[IW'(load_count_reg)] <= pos_reg;
        end
        if (cmd.edge_rd || cmd.edge_miss) begin
            vs_rd_reg <= vstore[vs_ra];
        end
        if (cmd.edge_miss) begin
            pu_reg <= vs_rd_reg;
        end
    end

    // Capture the request and track midpoint indices
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg <= tms_pkg::cmd_t'(s_cmd);
            pos_reg <= {s_pos_x, s_pos_y, s_pos_z};
            a_reg   <= corner_mod(s_corner_a);
            b_reg   <= corner_mod(s_corner_b);
            c_reg   <= corner_mod(s_corner_c);
        end
        if (cmd.hit_keep) begin
            mid_reg[cmd.edge_sel] <= map_rd_reg[OIW-1:0];
        end
        if (cmd.mid_emit) begin
            mid_reg[cmd.edge_sel] <= new_idx;
        end
    end

    // Counters, clear address and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            nni_reg        <= NNW'(tms_pkg::BASE_RESET);
            clr_addr_reg   <= '0;
            any_ovf_reg    <= 1'b0;
        end else begin
            if (cmd.capture) begin
                any_ovf_reg <= 1'b0;
            end
            if (cmd.begin_mesh) begin
                load_count_reg <= '0;
                nni_reg        <= NNW'(base_count);
                clr_addr_reg   <= '0;
            end
            if (cmd.load_store) begin
                load_count_reg <= load_count_reg + LCW'(1);
            end
            if (cmd.mid_emit) begin
                if (nni_full) begin
                    any_ovf_reg <= 1'b1;
                end else begin
                    nni_reg <= nni_reg + NNW'(1);
                end
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= (clr_addr_reg == AW'(MD - 1)) ? '0 : clr_addr_reg + AW'(1);
            end
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.load_store || cmd.mid_emit || cmd.tri_emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_store) begin
            m_kind         <= 1'b0;
            m_vert_idx     <= OIW'(load_count_reg);
            {m_out_x, m_out_y, m_out_z} <= pos_reg;
            m_tri_a        <= '0;
            m_tri_b        <= '0;
            m_tri_c        <= '0;
            m_last         <= 1'b1;
            m_overflow     <= 1'b0;
        end else if (cmd.mid_emit) begin
            m_kind         <= 1'b0;
            m_vert_idx     <= new_idx;
            {m_out_x, m_out_y, m_out_z} <= mid_pos;
            m_tri_a        <= '0;
            m_tri_b        <= '0;
            m_tri_c        <= '0;
            m_last         <= 1'b0;
            m_overflow     <= nni_full;
        end else if (cmd.tri_emit) begin
            m_kind         <= 1'b1;
            m_vert_idx     <= '0;
            {m_out_x, m_out_y, m_out_z} <= '0;
            m_last         <= (cmd.tri_sel == 2'd3);
            m_overflow     <= any_ovf_reg;
            case (cmd.tri_sel)
                2'd0: begin
                    m_tri_a <= OIW'(a_reg);
                    m_tri_b <= mid_reg[0];
                    m_tri_c <= mid_reg[2];
                end
                2'd1: begin
                    m_tri_a <= mid_reg[0];
                    m_tri_b <= OIW'(b_reg);
                    m_tri_c <= mid_reg[1];
                end
                2'd2: begin
                    m_tri_a <= mid_reg[2];
                    m_tri_b <= mid_reg[1];
                    m_tri_c <= OIW'(c_reg);
                end
                default: begin
                    m_tri_a <= mid_reg[2];
                    m_tri_b <= mid_reg[0];
                    m_tri_c <= mid_reg[1];
                end
            endcase
        end
    end

    // Status back to the controller
    always_comb begin
        sts.cmd       = cmd_reg;
        sts.load_full = (load_count_reg == LCW'(MAX_IN_VERTICES));
        sts.map_hit   = map_rd_reg[OIW];
        sts.out_free  = !m_valid || m_ready;
        sts.clr_last  = (clr_addr_reg == AW'(MD - 1));
    end

endmodule

@@ rtl/triangle_midpoint_subdivision.sv @@
// Triangle midpoint subdivision: splits each streamed triangle into four.
// Input, result and one configuration write channel, all valid/ready.
// Load requests (cmd 0) store a vertex and echo it with the next index (none if full).
// Triangle requests (cmd 1) look up each of their edges in the edge map; each
// missing edge gets a new index and emits its midpoint vertex, then four
// triangles follow. Begin (cmd 2) clears the map and resets both counters.
// One request at a time. A load passes accept, dispatch and store. A
// triangle passes accept and dispatch, then for each new edge a map read,
// a vertex read, the midpoint emit and a reverse write (a known edge only
// map read and check), then its four triangles. Other requests give none.
// A begin request, and reset, start a clearing pass over the edge map of
// MAX_IN_VERTICES squared entries (65536 by default); s_ready stays low.
// A stalled receiver holds the result register and the sequence waits on it.
// A written base count takes effect at the next begin; reset sets 12.
// Depends on tms_pkg, tms_ctrl and tms_datapath.
module triangle_midpoint_subdivision #(
    parameter int MAX_IN_VERTICES  = 256,
    parameter int MAX_OUT_VERTICES = 1024,
    parameter int COORD_BITS       = 18
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tms_pkg::BASE_W-1:0]           cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tms_pkg::CMD_W-1:0]            s_cmd,
    input  logic signed [COORD_BITS-1:0]         s_pos_x,
    input  logic signed [COORD_BITS-1:0]         s_pos_y,
    input  logic signed [COORD_BITS-1:0]         s_pos_z,
    input  logic [tms_pkg::CORNER_W-1:0]         s_corner_a,
    input  logic [tms_pkg::CORNER_W-1:0]         s_corner_b,
    input  logic [tms_pkg::CORNER_W-1:0]         s_corner_c,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic [$clog2(MAX_OUT_VERTICES)-1:0]  m_vert_idx,
    output logic signed [COORD_BITS-1:0]         m_out_x,
    output logic signed [COORD_BITS-1:0]         m_out_y,
    output logic signed [COORD_BITS-1:0]         m_out_z,
    output logic [$clog2(MAX_OUT_VERTICES)-1:0]  m_tri_a,
    output logic [$clog2(MAX_OUT_VERTICES)-1:0]  m_tri_b,
    output logic [$clog2(MAX_OUT_VERTICES)-1:0]  m_tri_c,
    output logic                                 m_last,
    output logic                                 m_overflow
);

    tms_pkg::dp_cmd_t           cmd;
    tms_pkg::dp_sts_t           sts;
    logic [tms_pkg::BASE_W-1:0] base_reg;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= tms_pkg::BASE_W'(tms_pkg::BASE_RESET);
        end else if (cfg_valid) begin
            base_reg <= cfg_data;
        end
    end

    tms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tms_datapath #(
        .MAX_IN_VERTICES  (MAX_IN_VERTICES),
        .MAX_OUT_VERTICES (MAX_OUT_VERTICES),
        .COORD_BITS       (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .base_count     (base_reg),
        .s_cmd          (s_cmd),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_corner_a     (s_corner_a),
        .s_corner_b     (s_corner_b),
        .s_corner_c     (s_corner_c),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_vert_idx     (m_vert_idx),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_out_z        (m_out_z),
        .m_tri_a        (m_tri_a),
        .m_tri_b        (m_tri_b),
        .m_tri_c        (m_tri_c),
        .m_last         (m_last),
        .m_overflow     (m_overflow)
    );

`ifndef SYNTH
    // Reset starts the map clearing pass, so no request is taken next cycle
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request taken right after reset");

    // One request at a time: accepting a request drops ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // A load echo never carries overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind && m_last |-> !m_overflow)
        else $error("overflow on load echo");
`endif

endmodule

@@ tb/tms_mesh_checker.sv @@
// Checker for the triangle midpoint subdivision block: watches the config,
// request and result channels, predicts every result and compares it.
// Depends on tms_pkg.
`timescale 1ns / 1ps

module tms_mesh_checker #(
    parameter int COORD_BITS = 18
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tms_pkg::BASE_W-1:0]    cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [tms_pkg::CMD_W-1:0]     s_cmd,
    input  logic signed [COORD_BITS-1:0]  s_pos_x,
    input  logic signed [COORD_BITS-1:0]  s_pos_y,
    input  logic signed [COORD_BITS-1:0]  s_pos_z,
    input  logic [tms_pkg::CORNER_W-1:0]  s_corner_a,
    input  logic [tms_pkg::CORNER_W-1:0]  s_corner_b,
    input  logic [tms_pkg::CORNER_W-1:0]  s_corner_c,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_kind,
    input  logic [9:0]                    m_vert_idx,
    input  logic signed [COORD_BITS-1:0]  m_out_x,
    input  logic signed [COORD_BITS-1:0]  m_out_y,
    input  logic signed [COORD_BITS-1:0]  m_out_z,
    input  logic [9:0]                    m_tri_a,
    input  logic [9:0]                    m_tri_b,
    input  logic [9:0]                    m_tri_c,
    input  logic                          m_last,
    input  logic                          m_overflow,
    output int                            fail_count,
    output int                            results_seen,
    output int                            outstanding,
    output int                            overflow_seen
);

    localparam int IN_VERTS  = 256;
    localparam int OUT_VERTS = 1024;

    typedef struct {
        bit                         kind;
        bit [9:0]                   vidx;
        bit signed [COORD_BITS-1:0] x, y, z;
        bit [9:0]                   ta, tb, tc;
        bit                         last;
        bit                         ovf;
    } mesh_result_t;

    mesh_result_t expected_results[$];

    logic signed [COORD_BITS-1:0] store_x [IN_VERTS];
    logic signed [COORD_BITS-1:0] store_y [IN_VERTS];
    logic signed [COORD_BITS-1:0] store_z [IN_VERTS];
    int midpoint_of_edge [int];
    int base_count;
    int load_count;
    int next_index;

    function automatic mesh_result_t blank_result();
        mesh_result_t r;
        r = '{default: 0};
        return r;
    endfunction

    // Look up an edge; allocate a midpoint and queue its vertex if missing
    function automatic bit [9:0] edge_midpoint(int u, int v, inout bit any_ovf);
        mesh_result_t r;
        logic signed [COORD_BITS:0] sum_x, sum_y, sum_z;
        bit [9:0] idx;
        bit ovf;
        if (midpoint_of_edge.exists(u * IN_VERTS + v))
            return 10'(midpoint_of_edge[u * IN_VERTS + v]);
        ovf = 1'b0;
        if (next_index >= OUT_VERTS) begin
            idx = 10'(OUT_VERTS - 1);
            ovf = 1'b1;
            any_ovf = 1'b1;
        end else begin
            idx = 10'(next_index);
            next_index++;
        end
        sum_x = store_x[u] + store_x[v];
        sum_y = store_y[u] + store_y[v];
        sum_z = store_z[u] + store_z[v];
        r = blank_result();
        r.vidx = idx;
        r.x = sum_x[COORD_BITS:1];
        r.y = sum_y[COORD_BITS:1];
        r.z = sum_z[COORD_BITS:1];
        r.ovf = ovf;
        expected_results.push_back(r);
        midpoint_of_edge[u * IN_VERTS + v] = idx;
        midpoint_of_edge[v * IN_VERTS + u] = idx;
        return idx;
    endfunction

    function automatic void push_triangle(bit [9:0] a, bit [9:0] b, bit [9:0] c,
                                          bit ovf, bit last);
        mesh_result_t r;
        r = blank_result();
        r.kind = 1'b1;
        r.ta = a;
        r.tb = b;
        r.tc = c;
        r.ovf = ovf;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    // Predict the results of one accepted request
    function automatic void subdivide_request();
        mesh_result_t r;
        int a, b, c;
        bit [9:0] ab, bc, ca;
        bit any_ovf;
        any_ovf = 1'b0;
        case (tms_pkg::cmd_t'(s_cmd))
            tms_pkg::CMD_LOAD: begin
                if (load_count < IN_VERTS) begin
                    store_x[load_count] = s_pos_x;
                    store_y[load_count] = s_pos_y;
                    store_z[load_count] = s_pos_z;
                    r = blank_result();
                    r.vidx = 10'(load_count);
                    r.x = s_pos_x;
                    r.y = s_pos_y;
                    r.z = s_pos_z;
                    r.last = 1'b1;
                    expected_results.push_back(r);
                    load_count++;
                end
            end
            tms_pkg::CMD_TRI: begin
                a = s_corner_a;
                b = s_corner_b;
                c = s_corner_c;
                ab = edge_midpoint(a, b, any_ovf);
                bc = edge_midpoint(b, c, any_ovf);
                ca = edge_midpoint(c, a, any_ovf);
                push_triangle(10'(a), ab, ca, any_ovf, 1'b0);
                push_triangle(ab, 10'(b), bc, any_ovf, 1'b0);
                push_triangle(ca, bc, 10'(c), any_ovf, 1'b0);
                push_triangle(ca, ab, bc, any_ovf, 1'b1);
            end
            tms_pkg::CMD_BEGIN: begin
                midpoint_of_edge.delete();
                load_count = 0;
                next_index = base_count;
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("result %0d field %s: expected %0d, got %0d",
                   results_seen, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Track config, predict on requests, compare on results
    always @(posedge aclk) begin
        mesh_result_t e;
        if (!aresetn) begin
            base_count = tms_pkg::BASE_RESET;
            load_count = 0;
            next_index = tms_pkg::BASE_RESET;
            midpoint_of_edge.delete();
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                base_count = cfg_data;
            if (s_valid && s_ready)
                subdivide_request();
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result, kind %0d", m_kind);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("kind", e.kind, m_kind);
                    check_field("vert_idx", e.vidx, m_vert_idx);
                    check_field("out_x", e.x, m_out_x);
                    check_field("out_y", e.y, m_out_y);
                    check_field("out_z", e.z, m_out_z);
                    check_field("tri_a", e.ta, m_tri_a);
                    check_field("tri_b", e.tb, m_tri_b);
                    check_field("tri_c", e.tc, m_tri_c);
                    check_field("last", e.last, m_last);
                    check_field("overflow", e.ovf, m_overflow);
                end
                if (m_overflow)
                    overflow_seen++;
                results_seen++;
            end
        end
        outstanding = expected_results.size();
    end

endmodule

@@ tb/tb_triangle_midpoint_subdivision.sv @@
// Top of the triangle midpoint subdivision testbench: clock, reset, request
// and result stimulus, config writes, watchdog and verdict.
// Depends on tms_pkg, the block and tms_mesh_checker.
`timescale 1ns / 1ps

module tb_triangle_midpoint_subdivision;

    localparam int COORD_BITS = 18;
    localparam int IDLE_LIMIT = 300000;
    localparam logic signed [COORD_BITS-1:0] C_MAX = 18'sh1FFFF;
    localparam logic signed [COORD_BITS-1:0] C_MIN = -18'sh20000;

    logic aclk;
    logic aresetn;
    logic cfg_valid, cfg_ready;
    logic [tms_pkg::BASE_W-1:0] cfg_data;
    logic s_valid, s_ready;
    logic [tms_pkg::CMD_W-1:0] s_cmd;
    logic signed [COORD_BITS-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic [tms_pkg::CORNER_W-1:0] s_corner_a, s_corner_b, s_corner_c;
    logic m_valid, m_ready, m_kind, m_last, m_overflow;
    logic [9:0] m_vert_idx, m_tri_a, m_tri_b, m_tri_c;
    logic signed [COORD_BITS-1:0] m_out_x, m_out_y, m_out_z;

    int fail_count, results_seen, outstanding, overflow_seen;
    int requests_sent;
    int loaded_hi;
    int idle_cycles;
    bit no_gaps;
    bit hold_req;
    logic [23:0] tri_history [$];

    triangle_midpoint_subdivision u_top (.*);

    tms_mesh_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Count cycles with no handshake anywhere; give up at the limit
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 10);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = 400;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(tms_pkg::cmd_t cmd, logic [17:0] px, logic [17:0] py,
                                logic [17:0] pz, int a, int b, int c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_cmd = cmd;
        s_pos_x = px;
        s_pos_y = py;
        s_pos_z = pz;
        s_corner_a = 8'(a);
        s_corner_b = 8'(b);
        s_corner_c = 8'(c);
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic load_vertex(logic [17:0] px, logic [17:0] py, logic [17:0] pz);
        send_request(tms_pkg::CMD_LOAD, px, py, pz, $urandom, $urandom, $urandom);
    endtask

    task automatic load_random();
        load_vertex(18'($urandom), 18'($urandom), 18'($urandom));
    endtask

    task automatic send_triangle(int a, int b, int c);
        tri_history.push_back({a[7:0], b[7:0], c[7:0]});
        send_request(tms_pkg::CMD_TRI, 18'($urandom), 18'($urandom), 18'($urandom),
                     a, b, c);
    endtask

    task automatic send_noise();
        send_request(tms_pkg::CMD_NONE, 18'($urandom), 18'($urandom), 18'($urandom),
                     $urandom, $urandom, $urandom);
    endtask

    // Drop valid, wait out all results, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (40) @(posedge aclk);
    endtask

    // Write the base count while idle, then start a new mesh with it
    task automatic new_mesh(int base);
        @(negedge aclk);
        cfg_data = 9'(base);
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        send_request(tms_pkg::CMD_BEGIN, 18'($urandom), 18'($urandom), 18'($urandom),
                     $urandom, $urandom, $urandom);
    endtask

    // Mixed random traffic over the first nverts stored vertices
    task automatic random_traffic(int count, int nverts);
        logic [23:0] t;
        int pick;
        repeat (count) begin
            if ($urandom_range(0, 49) == 0)
                no_gaps = ~no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 70 || tri_history.size() == 0) begin
                send_triangle($urandom_range(0, nverts - 1), $urandom_range(0, nverts - 1),
                              $urandom_range(0, nverts - 1));
            end else if (pick < 90) begin
                // repeat an earlier triangle, rotated, to hit known edges
                t = tri_history[$urandom_range(0, tri_history.size() - 1)];
                send_triangle(t[15:8], t[7:0], t[23:16]);
            end else if (pick < 95) begin
                send_noise();
            end else begin
                load_random();
            end
        end
    endtask

    initial begin
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_cmd = tms_pkg::CMD_NONE;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        s_corner_a = '0;
        s_corner_b = '0;
        s_corner_c = '0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        requests_sent = 0;
        idle_cycles = 0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: coordinate extremes, odd sums, shared, reversed and
        // degenerate edges, unused command
        load_vertex(C_MAX, C_MAX, C_MAX);
        load_vertex(C_MIN, C_MIN, C_MIN);
        load_vertex('0, 18'sd1, -18'sd1);
        load_vertex(-18'sd3, C_MAX, C_MIN);
        load_vertex(18'sd5, -18'sd7, 18'sd0);
        send_triangle(0, 1, 2);
        send_triangle(0, 1, 2);
        send_triangle(1, 0, 3);
        send_triangle(4, 4, 4);
        send_triangle(2, 3, 4);
        send_triangle(0, 0, 1);
        send_noise();
        send_triangle(3, 4, 0);
        drain();

        // Base count 1, small mesh with a long receiver hold-off
        new_mesh(1);
        repeat (10) load_random();
        hold_req = 1'b1;
        random_traffic(70, 10);
        drain();

        // Base count 256: fill the store and load once past it
        new_mesh(256);
        no_gaps = 1'b0;
        repeat (256) load_random();
        load_random();
        loaded_hi = 256;
        random_traffic(60, loaded_hi);
        drain();

        $display("Sent %0d requests, checked %0d results (%0d with overflow set),",
                 requests_sent, results_seen, overflow_seen);
        $display("base counts 12, 1 and 256, store filled and one load past it dropped.");
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
